// ----- hdl/sprite_art_decoder_core_macros.svh -----
// ----------------------------------------------------------------------------
// Sprite art decoder assertion macros
// Clocked assertion helpers used by the decoder core's RTL file.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ART_DECODER_CORE_MACROS_SVH
`define SPRITE_ART_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define SAD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sprite art decoder: assertion failed");

// expr must never be true outside reset
`define SAD_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sprite art decoder: forbidden condition seen");

`else

`define SAD_ASSERT(label, clk, rst, prop)
`define SAD_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- hdl/sad_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite art decoder package
// Types, constants and helper functions shared by the decoder's modules.
// ----------------------------------------------------------------------------
package sad_pkg;

   localparam logic [15:0] TILE_SIZE = 16'd44;
   localparam logic [15:0] TILE_HALF = 16'd22;
   localparam logic [16:0] RUN_GUARD = 17'd2048;

   localparam logic [15:0] WIDTH_RESET  = 16'd44;
   localparam logic [15:0] HEIGHT_RESET = 16'd44;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ART_KIND     = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_LEN    = 2'd1,
      PH_COLOUR = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PIXEL     = 2'd0,
      KIND_ROW_END   = 2'd1,
      KIND_ROW_ABORT = 2'd2
   } kind_type;

   typedef struct packed {
      logic        art_kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] column;
      logic [15:0] row;
      logic [15:0] run_left;
      logic [15:0] saved_skip;
      logic        image_done;
   } dec_state_type;

   typedef struct packed {
      logic        emit;
      kind_type    result_kind;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [15:0] colour;
      logic        image_last;
   } dec_result_type;

   function automatic dec_state_type clear_state();
      dec_state_type s;
      s.phase      = PH_SKIP;
      s.column     = '0;
      s.row        = '0;
      s.run_left   = '0;
      s.saved_skip = '0;
      s.image_done = 1'b0;
      return s;
   endfunction

   // first column of a diamond row
   function automatic logic [15:0] tile_start(input logic [15:0] y);
      logic [15:0] r;
      if (y < TILE_HALF) begin
         r = TILE_HALF - 16'd1 - y;
      end else begin
         r = y - TILE_HALF;
      end
      return r;
   endfunction

   // pixel count of a diamond row
   function automatic logic [15:0] tile_count(input logic [15:0] y);
      logic [15:0] r;
      if (y < TILE_HALF) begin
         r = {y[14:0], 1'b0} + 16'd2;
      end else begin
         r = {TILE_SIZE[14:0], 1'b0} - {y[14:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- hdl/sad_req_if.sv -----
// ----------------------------------------------------------------------------
// Sprite word channel
// Valid/ready channel carrying one sprite word and its frame start flag.
// ----------------------------------------------------------------------------
interface sad_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] data_word;
   logic        frame_start;

   modport source (output valid, output data_word, output frame_start, input ready);
   modport sink   (input valid, input data_word, input frame_start, output ready);
endinterface

// ----- hdl/sad_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Decoded pixel channel
// Valid/ready channel carrying one decoded pixel or row end.
// ----------------------------------------------------------------------------
interface sad_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] pixel_x;
   logic [15:0] pixel_y;
   logic [15:0] colour;
   logic        image_last;

   modport source (output valid, output result_kind, output pixel_x, output pixel_y,
                   output colour, output image_last, input ready);
   modport sink   (input valid, input result_kind, input pixel_x, input pixel_y,
                   input colour, input image_last, output ready);
endinterface

// ----- hdl/sad_csr.sv -----
// ----------------------------------------------------------------------------
// Sprite art decoder register block
// APB-style write and read access to the mode, width and height registers.
// ----------------------------------------------------------------------------
module sad_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sad_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sad_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sad_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output sad_pkg::cfg_type              cfg
);

   logic        art_kind_ff;
   logic [15:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic        wr_en;
   logic [1:0]  reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         art_kind_ff     <= 1'b0;
         image_width_ff  <= sad_pkg::WIDTH_RESET;
         image_height_ff <= sad_pkg::HEIGHT_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            sad_pkg::REG_ART_KIND:     art_kind_ff     <= csr_pwdata[0];
            sad_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[15:0];
            sad_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         sad_pkg::REG_ART_KIND:     csr_prdata = {31'd0, art_kind_ff};
         sad_pkg::REG_IMAGE_WIDTH:  csr_prdata = {16'd0, image_width_ff};
         sad_pkg::REG_IMAGE_HEIGHT: csr_prdata = {16'd0, image_height_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg.art_kind     = art_kind_ff;
   assign cfg.image_width  = image_width_ff;
   assign cfg.image_height = image_height_ff;

endmodule

// ----- hdl/sad_decode.sv -----
// ----------------------------------------------------------------------------
// Sprite art decoder word step
// Next decoder state and optional result for one sprite word.
// ----------------------------------------------------------------------------
module sad_decode (
   input  sad_pkg::cfg_type        cfg,
   input  sad_pkg::dec_state_type  state_cur,
   input  logic [15:0]             data_word,
   input  logic                    frame_start,
   output sad_pkg::dec_state_type  state_nxt,
   output sad_pkg::dec_result_type result
);

   always_comb begin
      sad_pkg::dec_state_type s;
      sad_pkg::dec_state_type nx;
      sad_pkg::dec_result_type o;
      logic [15:0] trow;
      logic [15:0] tcol;
      logic [15:0] ncol;
      logic [15:0] nrow;
      logic [16:0] sum;
      logic [15:0] skip_col;
      logic [15:0] run_nx;

      s  = frame_start ? sad_pkg::clear_state() : state_cur;
      nx = s;
      o  = '0;
      o.result_kind = sad_pkg::KIND_PIXEL;
      trow     = s.row;
      tcol     = s.column;
      ncol     = '0;
      nrow     = '0;
      sum      = {1'b0, s.saved_skip} + {1'b0, data_word};
      skip_col = s.column + s.saved_skip;
      run_nx   = s.run_left - 16'd1;

      if (!s.image_done) begin
         if (!cfg.art_kind) begin
            // diamond tile
            if (s.row >= sad_pkg::TILE_SIZE) begin
               nx.image_done = 1'b1;
            end else begin
               if (tcol >= sad_pkg::tile_count(trow)) begin
                  tcol = '0;
                  trow = trow + 16'd1;
               end
               if (trow >= sad_pkg::TILE_SIZE) begin
                  nx.column     = tcol;
                  nx.row        = trow;
                  nx.image_done = 1'b1;
               end else begin
                  ncol = tcol + 16'd1;
                  nrow = trow;
                  if (ncol >= sad_pkg::tile_count(trow)) begin
                     ncol = '0;
                     nrow = trow + 16'd1;
                  end
                  nx.column     = ncol;
                  nx.row        = nrow;
                  nx.image_done = (nrow >= sad_pkg::TILE_SIZE);
                  o.emit        = 1'b1;
                  o.pixel_x     = sad_pkg::tile_start(trow) + tcol;
                  o.pixel_y     = trow;
                  o.colour      = data_word;
                  o.image_last  = (nrow >= sad_pkg::TILE_SIZE);
               end
            end
         end else begin
            // run-length static
            if (s.row >= cfg.image_height) begin
               nx.image_done = 1'b1;
            end else begin
               case (s.phase)
                  sad_pkg::PH_LEN: begin
                     nx.column = skip_col;
                     if (sum >= sad_pkg::RUN_GUARD || sum == 17'd0) begin
                        nrow          = s.row + 16'd1;
                        o.emit        = 1'b1;
                        o.result_kind = (sum == 17'd0) ? sad_pkg::KIND_ROW_END
                                                       : sad_pkg::KIND_ROW_ABORT;
                        o.pixel_x     = skip_col;
                        o.pixel_y     = s.row;
                        o.image_last  = (nrow >= cfg.image_height);
                        nx.row        = nrow;
                        nx.image_done = (nrow >= cfg.image_height);
                        nx.column     = '0;
                        nx.phase      = sad_pkg::PH_SKIP;
                        nx.run_left   = '0;
                     end else if (data_word == 16'd0) begin
                        nx.phase = sad_pkg::PH_SKIP;
                     end else begin
                        nx.run_left = data_word;
                        nx.phase    = sad_pkg::PH_COLOUR;
                     end
                  end
                  sad_pkg::PH_COLOUR: begin
                     nx.column   = s.column + 16'd1;
                     nx.run_left = run_nx;
                     if (run_nx == 16'd0) begin
                        nx.phase = sad_pkg::PH_SKIP;
                     end
                     if (s.column < cfg.image_width) begin
                        o.emit    = 1'b1;
                        o.pixel_x = s.column;
                        o.pixel_y = s.row;
                        o.colour  = data_word;
                     end
                  end
                  default: begin
                     nx.saved_skip = data_word;
                     nx.phase      = sad_pkg::PH_LEN;
                  end
               endcase
            end
         end
      end

      state_nxt = nx;
      result    = o;
   end

endmodule

// ----- hdl/sprite_art_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Sprite art decoder core
// Turns a stream of 16-bit sprite words into pixel coordinates with colour.
// ----------------------------------------------------------------------------
// req_chan carries one sprite word per transfer; frame_start restarts the
// image before that word is used. rsp_chan carries at most one result per
// word: a pixel, or in run-length mode a normal or aborted row end, with
// image_last set on the final result of the image. Words after the image end
// give nothing until the next frame start.
// The csr_ port sets the mode (diamond tile or run-length static), the image
// width and the image height; write it only while the block is idle.
// Throughput is one word per cycle when unstalled: the whole step is one
// combinational pass from the decoder state and the word to the state and
// result registers. A result appears on rsp_chan in the cycle after its word's
// transfer. A single result register sits on rsp_chan; while it holds an
// untaken result req_chan.ready follows rsp_chan.ready, so a stalled receiver
// stalls input. Synchronous reset clears the decoder state and the output
// valid flag and sets the registers to tile mode, 44 by 44.
// ----------------------------------------------------------------------------
`include "sprite_art_decoder_core_macros.svh"

module sprite_art_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   sad_req_if.sink                       req_chan,
   sad_rsp_if.source                     rsp_chan,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sad_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sad_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sad_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);

   sad_pkg::cfg_type        cfg;
   sad_pkg::dec_state_type  state_ff;
   sad_pkg::dec_state_type  state_in;
   sad_pkg::dec_result_type step_res;
   sad_pkg::dec_result_type res_ff;
   logic                    out_valid_ff;
   logic                    req_fire;

   sad_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sad_decode u_decode (
      .cfg         (cfg),
      .state_cur   (state_ff),
      .data_word   (req_chan.data_word),
      .frame_start (req_chan.frame_start),
      .state_nxt   (state_in),
      .result      (step_res)
   );

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sad_pkg::clear_state();
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (req_chan.ready) begin
            out_valid_ff <= req_fire && step_res.emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && step_res.emit) begin
         res_ff <= step_res;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = res_ff.result_kind;
   assign rsp_chan.pixel_x     = res_ff.pixel_x;
   assign rsp_chan.pixel_y     = res_ff.pixel_y;
   assign rsp_chan.colour      = res_ff.colour;
   assign rsp_chan.image_last  = res_ff.image_last;

   `SAD_ASSERT(a_done_silent, clock, reset,
      (req_fire && state_ff.image_done && !req_chan.frame_start) |=> !rsp_chan.valid)
   `SAD_ASSERT(a_last_marks_done, clock, reset,
      (rsp_chan.valid && rsp_chan.image_last) |-> state_ff.image_done)
   `SAD_ASSERT(a_row_end_no_colour, clock, reset,
      (rsp_chan.valid && rsp_chan.result_kind != sad_pkg::KIND_PIXEL) |->
         (rsp_chan.colour == 16'd0))
   `SAD_NEVER(a_stall_blocks_input, clock, reset,
      rsp_chan.valid && !rsp_chan.ready && req_chan.ready)

endmodule
